@@ rtl/quant_scale_zero_point_assert.svh @@
// Assertion macros shared by the quantization scale and zero point block.
`ifndef QUANT_SCALE_ZERO_POINT_ASSERT_SVH
`define QUANT_SCALE_ZERO_POINT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QSZP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define QSZP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/qszp_pkg.sv @@
// Shared constants, types and states of the quantization scale block.
package qszp_pkg;

  localparam int unsigned InWidth    = 32;
  localparam int unsigned RangeWidth = 33;
  localparam int unsigned MultWidth  = 31;
  localparam int unsigned ShiftWidth = 6;
  localparam int unsigned NormWidth  = 5;   // normalization count, 0..24
  localparam int unsigned ProdWidth  = 64;
  localparam int unsigned DivSteps   = 31;  // one quotient bit per cell
  localparam int unsigned Q31Bits    = 31;
  localparam int unsigned NormBit    = 30;
  localparam int unsigned MinRange   = 256;
  localparam int unsigned ScaleNum   = 255; // start remainder: 255*2^31 >> 31

  // Payload carried down the divider row.
  typedef struct packed {
    logic [RangeWidth-1:0] rem;
    logic [RangeWidth-1:0] range;
    logic [MultWidth-1:0]  quo;
    logic [InWidth-1:0]    mn;
    logic                  err;
  } div_data_t;

  // One beat between neighbor cells.
  typedef struct packed {
    logic      valid;
    div_data_t data;
  } div_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_MUL,
    ST_RND,
    ST_SHIFT,
    ST_OUT
  } post_state_e;

endpackage

@@ rtl/qszp_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per beat.
module qszp_div_cell import qszp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_beat_t beat_i,
  output div_beat_t beat_o
);

  logic                  valid_q;
  div_data_t             data_q, data_d;
  logic [RangeWidth:0]   rem2;
  logic [RangeWidth:0]   rem_sub;
  logic                  ge;

  // Shift remainder in a zero bit, subtract divisor if it fits.
  always_comb begin
    rem2    = {beat_i.data.rem, 1'b0};
    rem_sub = rem2 - {1'b0, beat_i.data.range};
    ge      = (rem2 >= {1'b0, beat_i.data.range});
    data_d       = beat_i.data;
    data_d.rem   = ge ? rem_sub[RangeWidth-1:0] : rem2[RangeWidth-1:0];
    data_d.quo   = {beat_i.data.quo[MultWidth-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign beat_o = '{valid: valid_q, data: data_q};

endmodule

@@ rtl/qszp_div_chain.sv @@
// Row of division cells giving floor(255*2^31 / range).
module qszp_div_chain import qszp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_beat_t beat_i,
  output div_beat_t beat_o
);

  div_beat_t link [DivSteps+1];

  assign link[0] = beat_i;

  // Each cell hands its partial remainder to the next every cycle.
  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    qszp_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (link[i]),
      .beat_o (link[i+1])
    );
  end

  assign beat_o = link[DivSteps];

endmodule

@@ rtl/qszp_post.sv @@
// Normalize, multiply, round and saturate; holds the result register.
module qszp_post import qszp_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  div_beat_t                    beat_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic        [MultWidth-1:0]  scale_multiplier_o,
  output logic signed [ShiftWidth-1:0] scale_shift_o,
  output logic signed [InWidth-1:0]    zero_offset_o,
  output logic                         range_error_o
);

  post_state_e state_q, state_d;

  logic        [MultWidth-1:0]  mult_q, mult_d;
  logic        [NormWidth-1:0]  nsh_q, nsh_d;
  logic        [InWidth-1:0]    mn_q, mn_d;
  logic signed [ProdWidth-1:0]  prod_q, prod_d;
  logic        [MultWidth-1:0]  res_mult_q, res_mult_d;
  logic signed [ShiftWidth-1:0] res_shift_q, res_shift_d;
  logic signed [InWidth-1:0]    res_zp_q, res_zp_d;
  logic                         res_err_q, res_err_d;

  logic signed [RangeWidth-1:0] neg_mn;
  logic signed [ProdWidth-1:0]  prod_full;
  logic        [ShiftWidth-1:0] rnd_pos;
  logic        [ShiftWidth-1:0] shamt;
  logic signed [ProdWidth-1:0]  shifted;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (beat_i.valid) state_d = beat_i.data.err ? ST_OUT : ST_NORM;
      ST_NORM:  if (mult_q[NormBit]) state_d = ST_MUL;
      ST_MUL:   state_d = ST_RND;
      ST_RND:   state_d = ST_SHIFT;
      ST_SHIFT: state_d = ST_OUT;
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath arithmetic; the product always fits in 64 signed bits.
  always_comb begin
    neg_mn    = -$signed({mn_q[InWidth-1], mn_q});
    prod_full = neg_mn * $signed({1'b0, mult_q});
    rnd_pos   = ShiftWidth'(NormBit) + {1'b0, nsh_q};
    shamt     = ShiftWidth'(Q31Bits) + {1'b0, nsh_q};
    shifted   = prod_q >>> shamt;
  end

  // Register updates per state.
  always_comb begin
    mult_d      = mult_q;
    nsh_d       = nsh_q;
    mn_d        = mn_q;
    prod_d      = prod_q;
    res_mult_d  = res_mult_q;
    res_shift_d = res_shift_q;
    res_zp_d    = res_zp_q;
    res_err_d   = res_err_q;
    unique case (state_q)
      ST_IDLE: begin
        mult_d      = beat_i.data.quo;
        nsh_d       = '0;
        mn_d        = beat_i.data.mn;
        res_mult_d  = '0;
        res_shift_d = '0;
        res_zp_d    = '0;
        res_err_d   = 1'b1;
      end
      ST_NORM: begin
        if (!mult_q[NormBit]) begin
          mult_d = {mult_q[MultWidth-2:0], 1'b0};
          nsh_d  = nsh_q + NormWidth'(1);
        end
      end
      ST_MUL: prod_d = prod_full;
      ST_RND: prod_d = prod_q + (ProdWidth'(1) << rnd_pos);
      ST_SHIFT: begin
        res_mult_d  = mult_q;
        res_shift_d = ShiftWidth'(0) - ShiftWidth'({1'b0, nsh_q});
        res_err_d   = 1'b0;
        priority if (shifted > ProdWidth'(64'sh7FFF_FFFF)) begin
          res_zp_d = 32'sh7FFF_FFFF;
        end else if (shifted < -ProdWidth'(64'sh8000_0000)) begin
          res_zp_d = 32'sh8000_0000;
        end else begin
          res_zp_d = shifted[InWidth-1:0];
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  // Output handshake.
  always_comb begin
    out_valid_o        = (state_q == ST_OUT);
    scale_multiplier_o = res_mult_q;
    scale_shift_o      = res_shift_q;
    zero_offset_o      = res_zp_q;
    range_error_o      = res_err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mult_q      <= mult_d;
    nsh_q       <= nsh_d;
    mn_q        <= mn_d;
    prod_q      <= prod_d;
    res_mult_q  <= res_mult_d;
    res_shift_q <= res_shift_d;
    res_zp_q    <= res_zp_d;
    res_err_q   <= res_err_d;
  end

endmodule

@@ rtl/quant_scale_zero_point.sv @@
// Top level: quantization multiplier, shift and zero point from a min/max pair.
//
// Input channel: in_valid_i/in_ready_o carry one beat of min_value_i and
// max_value_i. Output channel: out_valid_o/out_ready_i carry one beat of
// scale_multiplier_o, scale_shift_o, zero_offset_o and range_error_o.
// One pair is in flight at a time; in_ready_o is low from acceptance until
// its result beat is taken.
// Sequence: stages A and B form the range, the row of division cells gives
// the quotient (one quotient bit per cell), the sequencer loads it, then
// normalizes it (one left shift per cycle, 0 to 24 shifts), then multiplies,
// rounds and shifts/saturates before out_valid_o is raised; a range below
// 256 skips straight from the loaded sequencer to the error result.
// Reset clears all valid flags and the sequencer; no clearing pass.
// A stalled receiver holds the result steady and keeps in_ready_o low.
module quant_scale_zero_point import qszp_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [InWidth-1:0]    min_value_i,
  input  logic signed [InWidth-1:0]    max_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic        [MultWidth-1:0]  scale_multiplier_o,
  output logic signed [ShiftWidth-1:0] scale_shift_o,
  output logic signed [InWidth-1:0]    zero_offset_o,
  output logic                         range_error_o
);

`include "quant_scale_zero_point_assert.svh"

  logic                         busy_q;
  logic                         in_fire, out_fire;
  logic                         va_q;
  logic        [InWidth-1:0]    mn_a_q;
  logic signed [RangeWidth-1:0] diff_a_q;
  logic        [RangeWidth-1:0] range_abs;
  logic                         vb_q;
  div_data_t                    data_b_q;
  div_beat_t                    beat_b;
  div_beat_t                    div_out;

  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;

  // Busy from acceptance until the result beat leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_fire) begin
      busy_q <= 1'b1;
    end else if (out_fire) begin
      busy_q <= 1'b0;
    end
  end

  // Stage A: signed difference at 33 bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mn_a_q   <= min_value_i;
      diff_a_q <= $signed({max_value_i[InWidth-1], max_value_i})
                - $signed({min_value_i[InWidth-1], min_value_i});
    end
  end

  // Stage B: magnitude, small-range check, seed the division row.
  assign range_abs = diff_a_q[RangeWidth-1] ? RangeWidth'(-diff_a_q)
                                            : RangeWidth'(diff_a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_b_q.rem   <= RangeWidth'(ScaleNum);
    data_b_q.range <= range_abs;
    data_b_q.quo   <= '0;
    data_b_q.mn    <= mn_a_q;
    data_b_q.err   <= (range_abs < RangeWidth'(MinRange));
  end

  assign beat_b = '{valid: vb_q, data: data_b_q};

  qszp_div_chain u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat_b),
    .beat_o (div_out)
  );

  qszp_post u_post (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .beat_i             (div_out),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .scale_multiplier_o (scale_multiplier_o),
    .scale_shift_o      (scale_shift_o),
    .zero_offset_o      (zero_offset_o),
    .range_error_o      (range_error_o)
  );

  // Checks.
  `QSZP_ASSERT_NOW(a_out_needs_item, out_valid_o, busy_q,
                   "result beat without an accepted item")
  `QSZP_ASSERT_NEXT(a_one_in_flight, in_fire, !in_ready_o,
                    "second item accepted while one is in flight")
  `QSZP_ASSERT_NOW(a_err_zero, out_valid_o && range_error_o,
                   scale_multiplier_o == 0 && scale_shift_o == 0 && zero_offset_o == 0,
                   "error result with nonzero fields")
  `QSZP_ASSERT_NOW(a_mult_norm, out_valid_o && !range_error_o,
                   scale_multiplier_o[NormBit],
                   "multiplier not normalized")

endmodule
